// ===== rtl/cmuvp_pkg.sv =====
// Package for the cube-map UV projection pipeline: payload types and constants.
package cmuvp_pkg;

  localparam int unsigned POS_W           = 32;
  localparam int unsigned UV_W            = 17;
  localparam int unsigned UV_FRAC_BITS_DF = 16;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } pos_t;

  typedef struct packed {
    logic [UV_W-1:0] tex_u;
    logic [UV_W-1:0] tex_v;
    logic            degenerate;
  } uv_t;

endpackage

// ===== rtl/cube_map_uv_projection.sv =====
// Cube-map UV projection: pipelined face select and rounded restoring divide.
//
//   channel | signals                            | dir | beat
//   --------+------------------------------------+-----+-----------------------
//   pos     | in_valid_i, in_ready_o, in_data_i  | in  | one vertex x, y, z
//   uv      | out_valid_o, out_ready_i, out_data_o | out | tex_u, tex_v, degenerate
//
// One beat per cycle while the output is not stalled. The pipe is, in order:
// three front stages (magnitudes, face select, numerator/denominator), then the
// divider at two quotient bits per stage, then the output register.
// Reset clears only the valid bits. A stall at the output freezes the whole pipe.
module cube_map_uv_projection #(
  parameter int unsigned UV_FRAC_BITS = cmuvp_pkg::UV_FRAC_BITS_DF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cmuvp_pkg::pos_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cmuvp_pkg::uv_t  out_data_o
);
  import cmuvp_pkg::*;

  localparam int unsigned NSTEP = UV_FRAC_BITS + 2;
  localparam int unsigned QW    = NSTEP;
  localparam int unsigned SPS   = 2;
  localparam int unsigned NSTG  = (NSTEP + SPS - 1) / SPS;
  localparam int unsigned RW    = POS_W + 2;
  localparam int unsigned CW    = POS_W + 1;
  localparam int unsigned QXW   = (QW > UV_W) ? QW : UV_W;

  logic en;

  // stage 1: magnitudes
  logic                    v1_q;
  logic signed [POS_W-1:0] x1_q, y1_q, z1_q;
  logic [POS_W-1:0]        ax1_q, ay1_q, az1_q;

  // stage 2: face select
  logic                 v2_q;
  logic signed [CW-1:0] uc2_q, vc2_q;
  logic [POS_W-1:0]     mx2_q;
  logic signed [CW-1:0] uc2_d, vc2_d;
  logic [POS_W-1:0]     mx2_d;

  // divider stages, index 0 loaded from the front end
  logic [NSTG:0]   vld_q;
  logic [RW-1:0]   remu_q [NSTG+1];
  logic [RW-1:0]   remv_q [NSTG+1];
  logic [RW-1:0]   den_q  [NSTG+1];
  logic [QW-1:0]   quou_q [NSTG+1];
  logic [QW-1:0]   quov_q [NSTG+1];
  logic            deg_q  [NSTG+1];

  logic            outv_q;
  uv_t             out_q;
  uv_t             out_d;

  assign en          = ~outv_q | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      vld_q  <= '0;
      outv_q <= 1'b0;
    end else if (en) begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      vld_q  <= {vld_q[NSTG-1:0], v2_q};
      outv_q <= vld_q[NSTG];
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= in_data_i.pos_x;
      y1_q  <= in_data_i.pos_y;
      z1_q  <= in_data_i.pos_z;
      ax1_q <= in_data_i.pos_x[POS_W-1] ? POS_W'(-in_data_i.pos_x) : in_data_i.pos_x;
      ay1_q <= in_data_i.pos_y[POS_W-1] ? POS_W'(-in_data_i.pos_y) : in_data_i.pos_y;
      az1_q <= in_data_i.pos_z[POS_W-1] ? POS_W'(-in_data_i.pos_z) : in_data_i.pos_z;
    end
  end

  // stage 2: zero counts as negative, ties go to Z then Y
  always_comb begin
    logic signed [CW-1:0] sx, sy, sz;
    logic                 zmaj, ymaj;
    sx   = CW'(x1_q);
    sy   = CW'(y1_q);
    sz   = CW'(z1_q);
    zmaj = (az1_q >= ax1_q) && (az1_q >= ay1_q);
    ymaj = (ay1_q >= ax1_q) && (ay1_q >= az1_q);
    if (zmaj) begin
      mx2_d = az1_q;
      uc2_d = (!z1_q[POS_W-1] && z1_q != '0) ? sx : -sx;
      vc2_d = sy;
    end else if (ymaj) begin
      mx2_d = ay1_q;
      uc2_d = sx;
      vc2_d = (!y1_q[POS_W-1] && y1_q != '0) ? -sz : sz;
    end else begin
      mx2_d = ax1_q;
      uc2_d = (!x1_q[POS_W-1] && x1_q != '0) ? -sz : sz;
      vc2_d = sy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      uc2_q <= uc2_d;
      vc2_q <= vc2_d;
      mx2_q <= mx2_d;
    end
  end

  // stage 3: numerators uc + mx (0 .. 2*mx), denominator 2*mx
  always_ff @(posedge clk_i) begin
    if (en) begin
      remu_q[0] <= RW'(RW'(uc2_q) + RW'(mx2_q));
      remv_q[0] <= RW'(RW'(vc2_q) + RW'(mx2_q));
      den_q[0]  <= {1'b0, mx2_q, 1'b0};
      quou_q[0] <= '0;
      quov_q[0] <= '0;
      deg_q[0]  <= (mx2_q == '0);
    end
  end

  // restoring divide: floor(top * 2^(F+1) / den), SPS bits per stage
  for (genvar s = 0; s < NSTG; s++) begin : g_div
    logic [RW-1:0] ru, rv;
    logic [QW-1:0] qu, qv;

    always_comb begin
      logic bu, bv;
      ru = remu_q[s];
      rv = remv_q[s];
      qu = quou_q[s];
      qv = quov_q[s];
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < NSTEP) begin
          if (s * SPS + k != 0) begin
            ru = ru << 1;
            rv = rv << 1;
          end
          bu = (ru >= den_q[s]);
          bv = (rv >= den_q[s]);
          if (bu) begin
            ru = ru - den_q[s];
          end
          if (bv) begin
            rv = rv - den_q[s];
          end
          qu = {qu[QW-2:0], bu};
          qv = {qv[QW-2:0], bv};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        remu_q[s+1] <= ru;
        remv_q[s+1] <= rv;
        quou_q[s+1] <= qu;
        quov_q[s+1] <= qv;
        den_q[s+1]  <= den_q[s];
        deg_q[s+1]  <= deg_q[s];
      end
    end
  end

  // round half up: (q2 + 1) >> 1, zero vector gives one half
  always_comb begin
    logic [QW:0]    su, sv;
    logic [QXW-1:0] eu, ev, half;
    su   = {1'b0, quou_q[NSTG]} + (QW+1)'(1);
    sv   = {1'b0, quov_q[NSTG]} + (QW+1)'(1);
    eu   = QXW'(su[QW:1]);
    ev   = QXW'(sv[QW:1]);
    half = QXW'(1) << (UV_FRAC_BITS - 1);
    if (deg_q[NSTG]) begin
      eu = half;
      ev = half;
    end
    out_d.tex_u      = eu[UV_W-1:0];
    out_d.tex_v      = ev[UV_W-1:0];
    out_d.degenerate = deg_q[NSTG];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== dv/tb_cube_map_uv_projection.sv =====
// Self-checking testbench for cube_map_uv_projection: directed and random vertices.
`timescale 1ns / 1ps

module tb_cube_map_uv_projection;
  import cmuvp_pkg::*;

  localparam int unsigned FRAC     = UV_FRAC_BITS_DF;
  localparam int          N_DIR    = 23;
  localparam int          N_RAND   = 1880;
  localparam int          DRAIN    = 24;
  localparam int          IDLE_MAX = 2000;

  localparam logic signed [POS_W-1:0] P_MIN = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] P_MAX = 32'sh7fff_ffff;
  localparam logic [UV_W-1:0] UV_HALF = 17'd32768;
  localparam logic [UV_W-1:0] UV_ONE  = 17'd65536;

  typedef struct packed {
    pos_t p;
    logic typed;
    uv_t  e;
  } vec_row_t;

  localparam vec_row_t VEC_TBL [N_DIR] = '{
    '{'{32'sd0, 32'sd0, 32'sd0},    1'b1, '{UV_HALF, UV_HALF, 1'b1}},
    '{'{32'sd1, 32'sd1, 32'sd1},    1'b1, '{UV_ONE, UV_ONE, 1'b0}},
    '{'{-32'sd1, -32'sd1, -32'sd1}, 1'b1, '{UV_ONE, 17'd0, 1'b0}},
    '{'{P_MIN, P_MIN, P_MIN},       1'b1, '{UV_ONE, 17'd0, 1'b0}},
    '{'{P_MAX, P_MAX, P_MAX},       1'b1, '{UV_ONE, UV_ONE, 1'b0}},
    '{'{P_MIN, 32'sd0, 32'sd0},     1'b1, '{UV_HALF, UV_HALF, 1'b0}},
    '{'{P_MAX, 32'sd0, 32'sd0},     1'b1, '{UV_HALF, UV_HALF, 1'b0}},
    '{'{32'sd0, P_MIN, 32'sd0},     1'b1, '{UV_HALF, UV_HALF, 1'b0}},
    '{'{32'sd0, 32'sd0, P_MAX},     1'b1, '{UV_HALF, UV_HALF, 1'b0}},
    '{'{32'sd3, 32'sd3, 32'sd0},    1'b1, '{UV_ONE, UV_HALF, 1'b0}},
    '{'{32'sd3, 32'sd0, 32'sd3},    1'b1, '{UV_ONE, UV_HALF, 1'b0}},
    '{'{32'sd5, 32'sd1, 32'sd2},    1'b0, '0},
    '{'{-32'sd5, 32'sd1, 32'sd2},   1'b0, '0},
    '{'{32'sd1, 32'sd5, 32'sd2},    1'b0, '0},
    '{'{32'sd1, -32'sd5, 32'sd2},   1'b0, '0},
    '{'{32'sd1, 32'sd2, 32'sd5},    1'b0, '0},
    '{'{32'sd1, 32'sd2, -32'sd5},   1'b0, '0},
    '{'{32'sd3, 32'sd1, 32'sd0},    1'b0, '0},
    '{'{P_MIN, P_MAX, 32'sd0},      1'b0, '0},
    '{'{P_MIN, P_MAX, P_MIN},       1'b0, '0},
    '{'{32'sd1, 32'sd0, 32'sd0},    1'b0, '0},
    '{'{-32'sd7, 32'sd3, -32'sd7},  1'b0, '0},
    '{'{32'sd0, 32'sd0, -32'sd1},   1'b0, '0}
  };

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  pos_t in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  uv_t  out_data_o;

  uv_t uv_pending [$];
  int  n_errors     = 0;
  int  n_vertices   = 0;
  int  n_results    = 0;
  int  n_degenerate = 0;
  int  idle_cycles  = 0;

  cube_map_uv_projection i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // rounded (num + mx) / (2*mx) in unsigned Q1.FRAC
  function automatic logic [UV_W-1:0] unit_ratio(input longint num, input longint mx);
    longint top;
    top = num + mx;
    return UV_W'(((top << FRAC) + mx) / (2 * mx));
  endfunction

  function automatic uv_t project_uv(input pos_t p);
    longint x, y, z, ax, ay, az, mx, uc, vc;
    uv_t    r;
    x  = longint'($signed(p.pos_x));
    y  = longint'($signed(p.pos_y));
    z  = longint'($signed(p.pos_z));
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    if (az >= ax && az >= ay) begin
      mx = az;
      uc = (z > 0) ? x : -x;
      vc = y;
    end else if (ay >= ax && ay >= az) begin
      mx = ay;
      uc = x;
      vc = (y > 0) ? -z : z;
    end else begin
      mx = ax;
      uc = (x > 0) ? -z : z;
      vc = y;
    end
    if (mx == 0) begin
      r.tex_u      = UV_W'(64'd1 << (FRAC - 1));
      r.tex_v      = r.tex_u;
      r.degenerate = 1'b1;
    end else begin
      r.tex_u      = unit_ratio(uc, mx);
      r.tex_v      = unit_ratio(vc, mx);
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_coord();
    int r;
    r = $urandom;
    return r >>> $urandom_range(0, 31);
  endfunction

  function automatic pos_t rand_vertex();
    logic signed [POS_W-1:0] c [3];
    logic signed [POS_W-1:0] v;
    int                      mode;
    mode = $urandom_range(0, 9);
    v    = rand_coord();
    for (int k = 0; k < 3; k++) begin
      case (mode)
        0, 1, 2: c[k] = $urandom;
        3, 4:    c[k] = $signed($urandom_range(0, 16)) - 8;
        5: begin
          // near or exact ties in magnitude, or a shifted-down copy of v
          case ($urandom_range(0, 3))
            0:       c[k] = v;
            1:       c[k] = -v;
            2:       c[k] = v + $signed($urandom_range(0, 2)) - 1;
            default: c[k] = v >>> $urandom_range(1, 4);
          endcase
        end
        6: begin
          case ($urandom_range(0, 5))
            0:       c[k] = P_MIN;
            1:       c[k] = P_MAX;
            2:       c[k] = 32'sd0;
            3:       c[k] = -32'sd1;
            4:       c[k] = 32'sd1;
            default: c[k] = rand_coord();
          endcase
        end
        default: c[k] = rand_coord();
      endcase
    end
    if (mode == 6 && $urandom_range(0, 3) == 0) begin
      c[0] = '0;
      c[1] = '0;
      c[2] = '0;
    end
    return '{c[0], c[1], c[2]};
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d (result %0d)",
             $realtime, what, got, want, n_results);
    n_errors++;
  endtask

  // receiver stall patterns, with mode and pattern redrawn at random
  int unsigned rx_cycle = 0;
  int unsigned rx_mode  = 0;
  logic [15:0] rx_pat   = 16'hffff;
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_pat  <= 16'($urandom) | 16'h0001;
    end
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= rx_pat[rx_cycle[3:0]];
      default: out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    uv_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (uv_pending.size() == 0) begin
        note_mismatch("beat with nothing pending, tex_u", out_data_o.tex_u, 0);
      end else begin
        want = uv_pending.pop_front();
        if (out_data_o.tex_u !== want.tex_u)
          note_mismatch("tex_u", out_data_o.tex_u, want.tex_u);
        if (out_data_o.tex_v !== want.tex_v)
          note_mismatch("tex_v", out_data_o.tex_v, want.tex_v);
        if (out_data_o.degenerate !== want.degenerate)
          note_mismatch("degenerate", out_data_o.degenerate, want.degenerate);
      end
      n_results++;
      if (out_data_o.degenerate === 1'b1) n_degenerate++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("Timeout: no beat moved for %0d cycles", IDLE_MAX);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    pos_t p;
    uv_t  e;
    int   burst;
    int   gap;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst = $urandom_range(1, 24);
    for (int i = 0; i < N_DIR + N_RAND; i++) begin
      if (i < N_DIR) begin
        p = VEC_TBL[i].p;
        e = VEC_TBL[i].typed ? VEC_TBL[i].e : project_uv(p);
      end else begin
        p = rand_vertex();
        e = project_uv(p);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= p;
      do @(posedge clk_i); while (!in_ready_o);
      uv_pending = {uv_pending, e};
      n_vertices++;
      burst--;
      if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(1, 24);
      end
    end
    in_valid_i <= 1'b0;
    while (uv_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("Sent %0d vertices (%0d directed, %0d random), checked %0d results",
             n_vertices, N_DIR, N_RAND, n_results);
    $display("Degenerate results: %0d, mismatches: %0d", n_degenerate, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== cube_map_uv_projection.f =====
rtl/cmuvp_pkg.sv
rtl/cube_map_uv_projection.sv
dv/tb_cube_map_uv_projection.sv
